// ===== design/two_queue_alternating_merge_macros.svh =====
// assertion macros used by the checker file of the two-queue merge block
// every macro samples on clk and is disabled while rst_n is low
`ifndef TWO_QUEUE_ALTERNATING_MERGE_MACROS_SVH
`define TWO_QUEUE_ALTERNATING_MERGE_MACROS_SVH

// property that must hold at every sampled edge
`define TQAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TQAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/tqam_pkg.sv =====
// shared constants and types of the two-queue alternating merge block
// no dependencies
`default_nettype none

package tqam_pkg;

  localparam int TICKET_W    = 16;
  localparam int OP_W        = 2;
  localparam int KIND_W      = 2;
  localparam int DEPTH_DEF   = 32;

  // request operation codes
  localparam logic [OP_W-1:0] OP_PUSH_A = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH_B = 2'd1;
  localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DROPPED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LISTED   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT
  } state_t;

endpackage

`default_nettype wire

// ===== design/two_queue_alternating_merge.sv =====
// two ticket queues (A and B) with an alternating merged read-out
// Input channel in_*: tuser carries the operation (push A, push B, list),
// tdata the 16-bit ticket. Result channel out_*: tuser carries the kind
// (accepted, dropped, listed), tdata the ticket (zero for push status),
// tlast marks the final result of a request.
// A push's status is in the output register the cycle after the request
// is taken, and the next request can be taken then if the receiver is ready.
// A list request walks the stored tickets A, B, A, B while both queues have
// entries, then the rest of the longer one; each ticket is a memory read
// (ST_READ), then a capture into the output register (ST_WAIT); in_tready
// stays low for the whole walk. Two empty queues give nothing.
// A full queue drops the push and reports it. Operation code 3 is taken
// and ignored. Reset empties both queues (no memory clearing pass).
// When the receiver stalls, the result holds in the output register, the
// walk pauses and no new request is taken.
`default_nettype none

module two_queue_alternating_merge
  import tqam_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [TICKET_W-1:0] in_tdata,   // [15:0] ticket
  input  wire logic [OP_W-1:0]     in_tuser,   // [1:0] operation
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic      [TICKET_W-1:0] out_tdata,  // [15:0] ticket_out
  output logic      [KIND_W-1:0]   out_tuser,  // [1:0] kind
  output logic                     out_tlast
);

  localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                we_a, we_b, re_a, re_b;
  logic [AW-1:0]       waddr, raddr;
  logic [TICKET_W-1:0] wdata, rdata_a, rdata_b;

  tqam_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .we_a       (we_a),
    .we_b       (we_b),
    .waddr      (waddr),
    .wdata      (wdata),
    .re_a       (re_a),
    .re_b       (re_b),
    .raddr      (raddr),
    .rdata_a    (rdata_a),
    .rdata_b    (rdata_b)
  );

  tqam_queue_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW)
  ) u_mem_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re_a),
    .raddr (raddr),
    .rdata (rdata_a)
  );

  tqam_queue_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW)
  ) u_mem_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re_b),
    .raddr (raddr),
    .rdata (rdata_b)
  );

endmodule

`default_nettype wire

// ===== design/tqam_queue_mem.sv =====
// ticket storage of one queue: one write port, one registered read port
// depends on tqam_pkg for the ticket width
`default_nettype none

module tqam_queue_mem
  import tqam_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEPTH_DEF,
  parameter int AW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       waddr,
  input  wire logic [TICKET_W-1:0] wdata,
  input  wire logic                re,
  input  wire logic [AW-1:0]       raddr,
  output logic      [TICKET_W-1:0] rdata
);

  logic [TICKET_W-1:0] mem [QUEUE_DEPTH];
  logic [TICKET_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/tqam_ctrl.sv =====
// sequencer of the merge block: fill counts, push handling, list walk
// and the output register; drives the two queue memories, uses tqam_pkg
`default_nettype none

module tqam_ctrl
  import tqam_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEPTH_DEF,
  parameter int AW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [TICKET_W-1:0] in_tdata,
  input  wire logic [OP_W-1:0]     in_tuser,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic      [TICKET_W-1:0] out_tdata,
  output logic      [KIND_W-1:0]   out_tuser,
  output logic                     out_tlast,
  output logic                     we_a,
  output logic                     we_b,
  output logic      [AW-1:0]       waddr,
  output logic      [TICKET_W-1:0] wdata,
  output logic                     re_a,
  output logic                     re_b,
  output logic      [AW-1:0]       raddr,
  input  wire logic [TICKET_W-1:0] rdata_a,
  input  wire logic [TICKET_W-1:0] rdata_b
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]    cnt_a_r, cnt_b_r;
  logic [CNT_W-1:0]    idx_a_r, idx_b_r;
  logic                turn_b_r;
  logic                sel_b_r;
  logic                out_valid_r;
  logic [TICKET_W-1:0] out_data_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic                out_last_r;

  logic                out_free;
  logic                in_acc;
  logic                have_a, have_b, pick_b;
  logic [CNT_W-1:0]    idx_a_inc, idx_b_inc;
  logic                walk_done;
  logic                full_a, full_b;
  logic                is_push;

  assign out_free  = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign have_a    = idx_a_r < cnt_a_r;
  assign have_b    = idx_b_r < cnt_b_r;
  // alternate while both have entries, then drain whichever is left
  assign pick_b    = !(have_a && (!turn_b_r || !have_b));
  assign idx_a_inc = idx_a_r + ONE_C;
  assign idx_b_inc = idx_b_r + ONE_C;
  assign walk_done = sel_b_r ? (!have_a && (idx_b_inc == cnt_b_r))
                             : (!have_b && (idx_a_inc == cnt_a_r));
  assign full_a    = cnt_a_r >= DEPTH_C;
  assign full_b    = cnt_b_r >= DEPTH_C;
  assign is_push   = (in_tuser == OP_PUSH_A) || (in_tuser == OP_PUSH_B);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == OP_LIST) &&
            ((cnt_a_r != '0) || (cnt_b_r != '0))) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (out_free) begin
          state_nxt = walk_done ? ST_IDLE : ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_tready = 1'b0;
    we_a      = 1'b0;
    we_b      = 1'b0;
    re_a      = 1'b0;
    re_b      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = out_free;
        we_a      = in_tvalid && out_free && (in_tuser == OP_PUSH_A) && !full_a;
        we_b      = in_tvalid && out_free && (in_tuser == OP_PUSH_B) && !full_b;
      end
      ST_READ: begin
        re_a = !pick_b;
        re_b = pick_b;
      end
      ST_WAIT: begin
      end
      default: begin
      end
    endcase
  end

  assign waddr = (in_tuser == OP_PUSH_B) ? cnt_b_r[AW-1:0] : cnt_a_r[AW-1:0];
  assign wdata = in_tdata;
  assign raddr = pick_b ? idx_b_r[AW-1:0] : idx_a_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (we_a) begin
        cnt_a_r <= cnt_a_r + ONE_C;
      end
      if (we_b) begin
        cnt_b_r <= cnt_b_r + ONE_C;
      end
      if ((in_acc && is_push) || ((state_r == ST_WAIT) && out_free)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walk indexes and result payload
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && in_acc) begin
      idx_a_r  <= '0;
      idx_b_r  <= '0;
      turn_b_r <= 1'b0;
    end
    if (state_r == ST_READ) begin
      sel_b_r <= pick_b;
    end
    if ((state_r == ST_WAIT) && out_free) begin
      if (sel_b_r) begin
        idx_b_r  <= idx_b_inc;
        turn_b_r <= 1'b0;
      end else begin
        idx_a_r  <= idx_a_inc;
        turn_b_r <= 1'b1;
      end
      out_kind_r <= KIND_LISTED;
      out_data_r <= sel_b_r ? rdata_b : rdata_a;
      out_last_r <= walk_done;
    end else if (in_acc && is_push) begin
      out_kind_r <= ((in_tuser == OP_PUSH_A) ? full_a : full_b) ? KIND_DROPPED
                                                                 : KIND_ACCEPTED;
      out_data_r <= '0;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ===== design/tqam_checker.sv =====
// port-level checks of the two-queue merge block, bound to the top level
// uses tqam_pkg and the macros header
`default_nettype none

`include "two_queue_alternating_merge_macros.svh"

module tqam_checker
  import tqam_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_tvalid,
  input wire logic                in_tready,
  input wire logic [OP_W-1:0]     in_tuser,
  input wire logic                out_tvalid,
  input wire logic                out_tready,
  input wire logic [TICKET_W-1:0] out_tdata,
  input wire logic [KIND_W-1:0]   out_tuser,
  input wire logic                out_tlast
);

  logic push_acc;
  assign push_acc = in_tvalid && in_tready &&
                    ((in_tuser == OP_PUSH_A) || (in_tuser == OP_PUSH_B));

  `TQAM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")
  `TQAM_ASSERT(a_kind_legal, !(out_tvalid && (out_tuser != KIND_ACCEPTED) && (out_tuser != KIND_DROPPED) && (out_tuser != KIND_LISTED)), "unknown result kind")
  `TQAM_ASSERT(a_status_shape, !(out_tvalid && (out_tuser != KIND_LISTED)) || (out_tlast && (out_tdata == '0)), "push status not single zero result")
  `TQAM_ASSERT_NEXT(a_push_status, push_acc, out_tvalid && out_tlast && ((out_tuser == KIND_ACCEPTED) || (out_tuser == KIND_DROPPED)), "push without status result")

endmodule

bind two_queue_alternating_merge tqam_checker u_tqam_checker (.*);

`default_nettype wire

// ===== tb/tb_two_queue_alternating_merge.sv =====
`timescale 1ns / 1ps
// testbench for two_queue_alternating_merge: directed and random push/list requests
// results are predicted by an in-bench copy of both queues; depends on tqam_pkg

module tb_two_queue_alternating_merge;
  import tqam_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [TICKET_W-1:0] ticket;
    logic                last;
  } merge_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [TICKET_W-1:0] in_tdata = '0;   // [15:0] ticket
  logic [OP_W-1:0]     in_tuser = '0;   // [1:0] operation
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [TICKET_W-1:0] out_tdata;       // [15:0] ticket_out
  logic [KIND_W-1:0]   out_tuser;       // [1:0] kind
  logic                out_tlast;

  merge_result_t       pending_results[$];
  logic [TICKET_W-1:0] queue_a_model[$];
  logic [TICKET_W-1:0] queue_b_model[$];

  int failures = 0;
  int quiet_cycles = 0;
  int hold_request = 0;
  int hold_left = 0;
  bit src_idling = 1'b1;
  bit sink_idling = 1'b1;

  two_queue_alternating_merge #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // receiver: random stalls, or a long hold-off counted down here
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(sink_idling && $urandom_range(99) < 18);
    end
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin
    merge_result_t seen;
    merge_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.kind = out_tuser;
      seen.ticket = out_tdata;
      seen.last = out_tlast;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: unexpected result kind %0d ticket %h last %b", $time,
                   seen.kind, seen.ticket, seen.last);
      end else begin
        want = pending_results.pop_front();
        if (seen.kind !== want.kind || seen.ticket !== want.ticket ||
            seen.last !== want.last) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("%0t: mismatch expected kind %0d ticket %h last %b, got kind %0d ticket %h last %b",
                     $time, want.kind, want.ticket, want.last,
                     seen.kind, seen.ticket, seen.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no traffic for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // update both queue copies and queue up the results of one request
  task automatic predict_merge(input logic [OP_W-1:0] op, input logic [TICKET_W-1:0] ticket);
    merge_result_t r;
    int total;
    int k;
    r = '0;
    k = 0;
    case (op)
      OP_PUSH_A, OP_PUSH_B: begin
        r.last = 1'b1;
        if (op == OP_PUSH_A) begin
          if (queue_a_model.size() < DEPTH) begin
            queue_a_model.push_back(ticket);
            r.kind = KIND_ACCEPTED;
          end else begin
            r.kind = KIND_DROPPED;
          end
        end else begin
          if (queue_b_model.size() < DEPTH) begin
            queue_b_model.push_back(ticket);
            r.kind = KIND_ACCEPTED;
          end else begin
            r.kind = KIND_DROPPED;
          end
        end
        pending_results.push_back(r);
      end
      OP_LIST: begin
        total = queue_a_model.size() + queue_b_model.size();
        r.kind = KIND_LISTED;
        // index-wise walk gives A, B, A, B and then the tail of the longer queue
        for (int i = 0; i < DEPTH; i++) begin
          if (i < queue_a_model.size()) begin
            k++;
            r.ticket = queue_a_model[i];
            r.last = (k == total);
            pending_results.push_back(r);
          end
          if (i < queue_b_model.size()) begin
            k++;
            r.ticket = queue_b_model[i];
            r.last = (k == total);
            pending_results.push_back(r);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_request(input logic [OP_W-1:0] op, input logic [TICKET_W-1:0] ticket);
    if (src_idling && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= ticket;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_merge(op, ticket);
  endtask

  // sender stays quiet until every expected result has come back
  task automatic wait_drained;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_list;
    send_request(OP_LIST, 16'h1234);
    send_request(OP_UNUSED, 16'hFFFF);
    wait_drained;
  endtask

  task automatic test_push_extremes;
    send_request(OP_PUSH_A, 16'h0000);
    send_request(OP_PUSH_B, 16'hFFFF);
    send_request(OP_PUSH_A, 16'h5555);
    send_request(OP_PUSH_B, 16'hAAAA);
    send_request(OP_PUSH_A, 16'h0001);
    wait_drained;
  endtask

  task automatic test_list_order;
    // A longer than B, then the same list again, then B longer
    send_request(OP_LIST, 16'h0000);
    send_request(OP_LIST, 16'hFFFF);
    send_request(OP_PUSH_B, 16'h8000);
    send_request(OP_PUSH_B, 16'h7FFF);
    send_request(OP_PUSH_B, 16'h1234);
    send_request(OP_LIST, 16'h0000);
    wait_drained;
  endtask

  task automatic test_backpressure;
    hold_request = HOLD_CYCLES;
    send_request(OP_PUSH_A, 16'h00FF);
    send_request(OP_PUSH_B, 16'hFF00);
    send_request(OP_LIST, 16'h0000);
    send_request(OP_PUSH_A, 16'h8001);
    wait_drained;
  endtask

  task automatic test_random_traffic(input int n_items);
    int pick;
    logic [OP_W-1:0] op;
    logic [TICKET_W-1:0] ticket;
    for (int i = 0; i < n_items; i++) begin
      // first stretch runs with no idling on either side
      src_idling = (i >= 40);
      sink_idling = (i >= 40);
      pick = $urandom_range(99);
      if (pick < 43)
        op = OP_PUSH_A;
      else if (pick < 86)
        op = OP_PUSH_B;
      else if (pick < 96)
        op = OP_LIST;
      else
        op = OP_UNUSED;
      case ($urandom_range(9))
        0: ticket = '0;
        1: ticket = '1;
        default: ticket = TICKET_W'($urandom_range(16'hFFFF));
      endcase
      send_request(op, ticket);
    end
    send_request(OP_LIST, 16'h0000);
    wait_drained;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_list;
    test_push_extremes;
    test_list_order;
    test_backpressure;
    test_random_traffic(112);
    repeat (8) @(posedge clk);
    if (failures == 0 && pending_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
